// ----- rtl/sit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  // FNV prime is 2^40 + 0x1B3
  localparam int FNV_PRIME_SHIFT = 40;
  localparam logic [8:0] FNV_PRIME_LOW = 9'h1B3;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int MAX_NAME_BYTES_DEF = 32;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/symbol_intern_hash_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Symbol interning table. Names arrive one byte per transaction on the input
// queue port (push/full, name_byte, last_byte); last_byte closes a name.
// Each name yields one result on the output queue port (empty/pop, status,
// slot): found, inserted, table full or name too long.
// The front hashes one byte per cycle (FNV-1a, 64 bit) into one of two
// staging banks; a two-entry queue hands finished names to the back, which
// probes the table. For each name the back dequeues it, probes slots, compares
// bytes on a hash hit or copies them on insert, and then emits the result.
// The front keeps taking bytes of the next name while the back works, and
// stalls (full high) only when both staging banks are still in use.
// TABLE_SLOTS must be a power of two so the probe sequence covers the table.
// Reset is synchronous and empties the table and the output.
// When the receiver does not pop, the result holds and the back waits,
// after which the front fills up and raises full.
module symbol_intern_hash_table_unit
  import sit_pkg::*;
#(
  parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
  parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] name_byte,
  input  wire logic       last_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      status,
  output logic [5:0]      slot
);
  localparam int LW = $clog2(MAX_NAME_BYTES + 1);
  localparam int IW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
  localparam int DW = 64 + LW + 2;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  logic [DW-1:0] q_wdata;
  logic [DW-1:0] q_rdata;
  logic          stg_we;
  logic [IW:0]   stg_waddr;
  logic [7:0]    stg_wdata;
  logic          rel;
  logic          rel_bank;
  status_t       st;

  assign status = st;

  sit_front #(.MAX(MAX_NAME_BYTES), .LW(LW), .IW(IW), .DW(DW)) u_front (
    .clk, .rst, .push, .full, .name_byte, .last_byte,
    .q_full, .q_push, .q_data(q_wdata),
    .stg_we, .stg_waddr, .stg_wdata, .rel, .rel_bank
  );

  sit_queue #(.DW(DW)) u_queue (
    .clk, .rst, .wr(q_push), .wdata(q_wdata), .q_full,
    .rd(q_pop), .rdata(q_rdata), .q_empty
  );

  sit_back #(
    .SLOTS(TABLE_SLOTS), .MAX(MAX_NAME_BYTES), .LW(LW), .IW(IW), .DW(DW)
  ) u_back (
    .clk, .rst, .q_empty, .q_data(q_rdata), .q_pop,
    .stg_we, .stg_waddr, .stg_wdata, .rel, .rel_bank,
    .empty, .pop, .status(st), .slot
  );
endmodule
`default_nettype wire

// ----- rtl/sit_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sit_queue #(
  parameter int DW = 72
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire logic [DW-1:0] wdata,
  output logic               q_full,
  input  wire logic          rd,
  output logic [DW-1:0]      rdata,
  output logic               q_empty
);
  logic [DW-1:0] mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;

  assign q_full  = (cnt == 2'd2);
  assign q_empty = (cnt == 2'd0);
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr && !q_full) begin
        wp <= ~wp;
      end
      if (rd && !q_empty) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((wr && !q_full) ? 1 : 0) - 2'((rd && !q_empty) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sit_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sit_front #(
  parameter int MAX = 32,
  parameter int LW  = 6,
  parameter int IW  = 5,
  parameter int DW  = 72
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    name_byte,
  input  wire logic          last_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output logic [DW-1:0]      q_data,
  output logic               stg_we,
  output logic [IW:0]        stg_waddr,
  output logic [7:0]         stg_wdata,
  input  wire logic          rel,
  input  wire logic          rel_bank
);
  import sit_pkg::*;

  logic [63:0]   hash;
  logic [LW-1:0] len;
  logic          ovf;
  logic          fbank;
  logic [1:0]    busy;

  logic          acc;
  logic [63:0]   x;
  logic [63:0]   hash_next;
  logic [LW-1:0] len_next;
  logic          ovf_next;
  logic          room;

  assign full = busy[fbank] | q_full;
  assign acc  = push & ~full;
  assign x    = hash ^ {56'd0, name_byte};
  // multiply by 2^40 + 0x1B3 as a shift plus a narrow product
  assign hash_next = (x << FNV_PRIME_SHIFT) + 64'(x * {55'd0, FNV_PRIME_LOW});
  assign room      = (len < LW'(MAX));
  assign len_next  = room ? len + LW'(1) : len;
  assign ovf_next  = ovf | ~room;

  assign stg_we    = acc & room;
  assign stg_waddr = {fbank, len[IW-1:0]};
  assign stg_wdata = name_byte;
  assign q_push    = acc & last_byte;
  assign q_data    = {fbank, ovf_next, len_next, hash_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      hash  <= FNV_BASIS;
      len   <= '0;
      ovf   <= 1'b0;
      fbank <= 1'b0;
      busy  <= 2'b00;
    end else begin
      if (rel) begin
        busy[rel_bank] <= 1'b0;
      end
      if (acc) begin
        if (last_byte) begin
          hash        <= FNV_BASIS;
          len         <= '0;
          ovf         <= 1'b0;
          busy[fbank] <= 1'b1;
          fbank       <= ~fbank;
        end else begin
          hash <= hash_next;
          len  <= len_next;
          ovf  <= ovf_next;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sit_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sit_back #(
  parameter int SLOTS = 64,
  parameter int MAX   = 32,
  parameter int LW    = 6,
  parameter int IW    = 5,
  parameter int DW    = 72
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire logic [DW-1:0] q_data,
  output logic               q_pop,
  input  wire logic          stg_we,
  input  wire logic [IW:0]   stg_waddr,
  input  wire logic [7:0]    stg_wdata,
  output logic               rel,
  output logic               rel_bank,
  output logic               empty,
  input  wire logic          pop,
  output sit_pkg::status_t   status,
  output logic [5:0]         slot
);
  import sit_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int UW = $clog2(SLOTS + 1);
  localparam int BW = $clog2(SLOTS * MAX);

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_CHECK, S_CMP_RD, S_CMP_CK, S_CPY_RD, S_CPY_WR, S_EMIT
  } state_t;

  state_t        state;
  logic [63:0]   hash;
  logic [LW-1:0] len;
  logic          bank;
  logic [SW-1:0] idx;
  logic [SW-1:0] coll;
  logic [PW-1:0] probes;
  logic [LW-1:0] j;
  logic [UW-1:0] used;
  logic [SLOTS-1:0] valid;
  status_t       r_status;
  logic [SW-1:0] r_slot;
  logic          oval;

  logic [63:0]   hash_mem [SLOTS];
  logic [LW-1:0] len_mem  [SLOTS];
  logic [7:0]    byte_mem [SLOTS*MAX];
  logic [7:0]    stg_mem  [2*(2**IW)];
  logic [63:0]   h_q;
  logic [LW-1:0] l_q;
  logic [7:0]    stg_q;
  logic [7:0]    byte_q;

  logic [BW-1:0] byte_addr;
  logic [IW:0]   stg_raddr;
  logic          lim;
  logic          ins_go;
  logic          cpy_we;
  logic [SW-1:0] idx_adv;
  logic          probe_last;
  logic          j_last;

  assign byte_addr  = BW'(BW'(idx) * BW'(MAX)) + BW'(j);
  assign stg_raddr  = {bank, j[IW-1:0]};
  assign lim        = ((({2'b00, used} + (UW+2)'(1)) << 1) > (UW+2)'(SLOTS));
  assign ins_go     = (state == S_CHECK) && !valid[idx] && !lim;
  assign cpy_we     = (state == S_CPY_WR);
  assign idx_adv    = idx + coll + SW'(1);
  assign probe_last = (probes == PW'(SLOTS - 1));
  assign j_last     = ((j + LW'(1)) == len);
  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign empty      = ~oval;

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= stg_wdata;
    end
    stg_q <= stg_mem[stg_raddr];
  end

  always_ff @(posedge clk) begin
    if (ins_go) begin
      hash_mem[idx] <= hash;
      len_mem[idx]  <= len;
    end
    h_q <= hash_mem[idx];
    l_q <= len_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cpy_we) begin
      byte_mem[byte_addr] <= stg_q;
    end
    byte_q <= byte_mem[byte_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      used     <= '0;
      oval     <= 1'b0;
      rel      <= 1'b0;
      rel_bank <= 1'b0;
      status   <= ST_FOUND;
      slot     <= '0;
      r_status <= ST_FOUND;
      r_slot   <= '0;
      hash     <= '0;
      len      <= '0;
      bank     <= 1'b0;
      idx      <= '0;
      coll     <= '0;
      probes   <= '0;
      j        <= '0;
    end else begin
      rel <= 1'b0;
      if (pop && oval) begin
        oval <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            hash   <= q_data[63:0];
            len    <= q_data[64 +: LW];
            bank   <= q_data[65 + LW];
            idx    <= q_data[SW-1:0];
            coll   <= '0;
            probes <= '0;
            if (q_data[64 + LW]) begin
              r_status <= ST_TOO_LONG;
              r_slot   <= '0;
              state    <= S_EMIT;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          j <= '0;
          if (!valid[idx]) begin
            if (lim) begin
              r_status <= ST_FULL;
              r_slot   <= '0;
              state    <= S_EMIT;
            end else begin
              valid[idx] <= 1'b1;
              used       <= used + UW'(1);
              if (len == '0) begin
                r_status <= ST_INSERTED;
                r_slot   <= idx;
                state    <= S_EMIT;
              end else begin
                state <= S_CPY_RD;
              end
            end
          end else if (h_q == hash && l_q == len) begin
            if (len == '0) begin
              r_status <= ST_FOUND;
              r_slot   <= idx;
              state    <= S_EMIT;
            end else begin
              state <= S_CMP_RD;
            end
          end else if (probe_last) begin
            r_status <= ST_FULL;
            r_slot   <= '0;
            state    <= S_EMIT;
          end else begin
            idx    <= idx_adv;
            coll   <= coll + SW'(1);
            probes <= probes + PW'(1);
            state  <= S_PROBE;
          end
        end
        S_CMP_RD: begin
          state <= S_CMP_CK;
        end
        S_CMP_CK: begin
          if (stg_q != byte_q) begin
            // mismatch: move on to the next probe slot
            if (probe_last) begin
              r_status <= ST_FULL;
              r_slot   <= '0;
              state    <= S_EMIT;
            end else begin
              idx    <= idx_adv;
              coll   <= coll + SW'(1);
              probes <= probes + PW'(1);
              state  <= S_PROBE;
            end
          end else if (j_last) begin
            r_status <= ST_FOUND;
            r_slot   <= idx;
            state    <= S_EMIT;
          end else begin
            j     <= j + LW'(1);
            state <= S_CMP_RD;
          end
        end
        S_CPY_RD: begin
          state <= S_CPY_WR;
        end
        S_CPY_WR: begin
          if (j_last) begin
            r_status <= ST_INSERTED;
            r_slot   <= idx;
            state    <= S_EMIT;
          end else begin
            j     <= j + LW'(1);
            state <= S_CPY_RD;
          end
        end
        S_EMIT: begin
          if (!oval || pop) begin
            oval     <= 1'b1;
            status   <= r_status;
            slot     <= 6'(r_slot);
            rel      <= 1'b1;
            rel_bank <= bank;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sit_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sit_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [1:0] status,
  input wire logic [5:0] slot
);
  import sit_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("output not empty or input full after reset");

  a_error_slot: assert property (@(posedge clk) disable iff (rst)
    !empty && (status == ST_FULL || status == ST_TOO_LONG) |-> slot == 6'd0)
    else $error("nonzero slot on an error status");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(slot))
    else $error("stalled result changed");

  // a result never appears out of nothing right after reset
  a_no_early: assert property (@(posedge clk) rst ##1 !rst |=> empty)
    else $error("result without any name");
endmodule

bind symbol_intern_hash_table_unit sit_checker u_sit_checker (
  .clk, .rst, .full, .empty, .pop, .status, .slot
);
`default_nettype wire
